// ----- rtl/core/thwf_pkg.sv -----
// Shared constants, register codes and stage types for the threshold window hit finder.
// No dependencies; every other file of the block imports this package.
package thwf_pkg;

	localparam int MAX_WIDTH  = 16;
	localparam int MAX_TICKS  = 16384;

	// Deepest sample the window ever reads; width two needs three ticks.
	localparam int HIST_DEPTH = (MAX_WIDTH < 3) ? 3 : MAX_WIDTH;
	localparam int HIDX_W     = $clog2(HIST_DEPTH);

	localparam int SAMPLE_W   = 16;
	localparam int WREG_W     = 5;
	localparam int EW_W       = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W      = ((WREG_W > EW_W) ? WREG_W : EW_W) + 1;
	localparam int SPAN_W     = $clog2(HIST_DEPTH + 1);
	localparam int TICK_W     = $clog2(MAX_TICKS + 1);
	localparam int T1_W       = TICK_W + 1;
	localparam int CIDX_W     = $clog2(MAX_TICKS);
	localparam int PLANE_W    = 2;
	localparam int WIRE_W     = 16;
	localparam int PT_W       = 15;
	localparam int ST_W       = 16;
	localparam int ET_W       = 16;
	localparam int CHG_W      = 20;
	localparam int PK_W       = 17;

	// Charge adder tree: groups of four samples, then one final sum.
	localparam int GRP        = 4;
	localparam int NGRP       = (HIST_DEPTH + GRP - 1) / GRP;
	localparam int GSUM_W     = SAMPLE_W + $clog2(GRP);
	localparam int SUM_W      = SAMPLE_W + $clog2(HIST_DEPTH);
	localparam int ACC_W      = ((SUM_W > CHG_W) ? SUM_W : CHG_W) + 1;
	localparam int CHG_MAX    = 2 ** (CHG_W - 1) - 1;
	localparam int CHG_MIN    = -(2 ** (CHG_W - 1));

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PEAK_IND = 3'd0,
		REG_PEAK_COL = 3'd1,
		REG_TAIL_IND = 3'd2,
		REG_TAIL_COL = 3'd3,
		REG_WIDTH_IND = 3'd4,
		REG_WIDTH_COL = 3'd5
	} cfg_reg_e;

	typedef struct packed {
		sample_t             peak_ind;
		sample_t             peak_col;
		sample_t             tail_ind;
		sample_t             tail_col;
		logic [WREG_W-1:0]   width_ind;
		logic [WREG_W-1:0]   width_col;
	} cfg_t;

	// Per-sample control captured at acceptance.
	typedef struct packed {
		logic                elig;
		logic                even;
		logic                lo;
		logic [HIDX_W-1:0]   hi;
		logic [HIDX_W-1:0]   dc;
		logic [EW_W-1:0]     weff;
		sample_t             pthr;
		sample_t             tthr;
		logic [PLANE_W-1:0]  plane;
		logic [WIRE_W-1:0]   wire_id;
		logic [CIDX_W-1:0]   c;
	} win_t;

	// Window evaluation results, one stage before the output register.
	typedef struct packed {
		logic                          hit_ok;
		logic [NGRP-1:0][GSUM_W-1:0]   gsum;
		logic [PLANE_W-1:0]            plane;
		logic [WIRE_W-1:0]             wire_id;
		logic [PT_W-1:0]               pt;
		logic signed [ST_W-1:0]        st;
		logic [ET_W-1:0]               et;
		logic signed [PK_W-1:0]        peak_half;
	} eval_t;

endpackage

// ----- rtl/core/thwf_if.sv -----
// Valid/ready channel interfaces for wire samples and hits.
// Depends on thwf_pkg for field widths.
interface thwf_sample_if;
	import thwf_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       is_collection;
	logic [PLANE_W-1:0]         plane;
	logic [WIRE_W-1:0]          wire_number;
	logic                       last_of_wire;

	modport source (output valid, sample, is_collection, plane, wire_number, last_of_wire,
		input ready);
	modport sink (input valid, sample, is_collection, plane, wire_number, last_of_wire,
		output ready);
endinterface

interface thwf_hit_if;
	import thwf_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [PLANE_W-1:0]      hit_plane;
	logic [WIRE_W-1:0]       hit_wire;
	logic [PT_W-1:0]         peak_time_half;
	logic signed [ST_W-1:0]  start_time_half;
	logic [ET_W-1:0]         end_time_half;
	logic signed [CHG_W-1:0] total_charge;
	logic signed [PK_W-1:0]  peak_value_half;

	modport source (output valid, hit_plane, hit_wire, peak_time_half, start_time_half,
		end_time_half, total_charge, peak_value_half, input ready);
	modport sink (input valid, hit_plane, hit_wire, peak_time_half, start_time_half,
		end_time_half, total_charge, peak_value_half, output ready);
endinterface

// ----- rtl/core/thwf_cfg_regs.sv -----
// Configuration register file: thresholds and window widths per wire type.
// Depends on thwf_pkg.
module thwf_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [thwf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [thwf_pkg::CFG_DATA_W-1:0]   cfg_data,
	output thwf_pkg::cfg_t                    cfg
);
	import thwf_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.peak_ind  <= sample_t'(0);
			cfg_q.peak_col  <= sample_t'(0);
			cfg_q.tail_ind  <= sample_t'(-1584);
			cfg_q.tail_col  <= sample_t'(-1584);
			cfg_q.width_ind <= WREG_W'(3);
			cfg_q.width_col <= WREG_W'(3);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PEAK_IND:  cfg_q.peak_ind  <= sample_t'(cfg_data[SAMPLE_W-1:0]);
				REG_PEAK_COL:  cfg_q.peak_col  <= sample_t'(cfg_data[SAMPLE_W-1:0]);
				REG_TAIL_IND:  cfg_q.tail_ind  <= sample_t'(cfg_data[SAMPLE_W-1:0]);
				REG_TAIL_COL:  cfg_q.tail_col  <= sample_t'(cfg_data[SAMPLE_W-1:0]);
				REG_WIDTH_IND: cfg_q.width_ind <= cfg_data[WREG_W-1:0];
				REG_WIDTH_COL: cfg_q.width_col <= cfg_data[WREG_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/thwf_window.sv -----
// Sample history, tick counter and first pipeline stage (window geometry per sample).
// Depends on thwf_pkg and thwf_sample_if.
module thwf_window (
	input  logic                clk,
	input  logic                arst_n,
	thwf_sample_if.sink         samples,
	input  thwf_pkg::cfg_t      cfg,
	input  logic                s1_take,
	output logic                valid_s1_o,
	output thwf_pkg::win_t      win_o,
	output thwf_pkg::sample_t   hist_o [thwf_pkg::HIST_DEPTH]
);
	import thwf_pkg::*;

	sample_t            hist_q [HIST_DEPTH];
	logic [TICK_W-1:0]  tick_q;
	logic               valid_s1;
	win_t               win_s1;

	logic               accept;
	logic               in_range;
	logic [T1_W-1:0]    t1;
	logic [WREG_W-1:0]  wreg;
	logic [EW_W-1:0]    weff;
	logic [EW_W-1:0]    half;
	logic               w2;
	logic [SPAN_W-1:0]  span;
	win_t               win_d;

	assign samples.ready = !valid_s1 || s1_take;
	assign accept        = samples.valid && samples.ready;
	assign in_range      = tick_q < TICK_W'(MAX_TICKS);
	assign t1            = T1_W'(tick_q) + T1_W'(1);

	always_comb begin
		wreg = samples.is_collection ? cfg.width_col : cfg.width_ind;
		if (wreg == '0) begin
			weff = EW_W'(1);
		end else if (CMP_W'(wreg) > CMP_W'(MAX_WIDTH)) begin
			weff = EW_W'(MAX_WIDTH);
		end else begin
			weff = EW_W'(wreg);
		end
		half = weff >> 1;
		// width two reads one tick past its window for the peak
		w2   = (weff == EW_W'(2));
		span = w2 ? SPAN_W'(3) : SPAN_W'(weff);

		win_d.elig    = in_range && (t1 >= T1_W'(span));
		win_d.even    = ~weff[0];
		win_d.lo      = w2;
		win_d.hi      = HIDX_W'(span - SPAN_W'(1));
		win_d.dc      = HIDX_W'(span - SPAN_W'(1) - SPAN_W'(half));
		win_d.weff    = weff;
		win_d.pthr    = samples.is_collection ? cfg.peak_col : cfg.peak_ind;
		win_d.tthr    = samples.is_collection ? cfg.tail_col : cfg.tail_ind;
		win_d.plane   = samples.plane;
		win_d.wire_id = samples.wire_number;
		win_d.c       = CIDX_W'(t1 - T1_W'(span) + T1_W'(half));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (samples.ready) begin
				valid_s1 <= samples.valid;
			end
			if (accept) begin
				if (samples.last_of_wire) begin
					tick_q <= '0;
				end else if (in_range) begin
					tick_q <= TICK_W'(t1);
				end
			end
		end
	end

	// History holds no reset: ticks before the wire start are never read.
	always_ff @(posedge clk) begin
		if (accept) begin
			win_s1 <= win_d;
			if (in_range) begin
				hist_q[0] <= samples.sample;
				for (int k = 1; k < HIST_DEPTH; k++) begin
					hist_q[k] <= hist_q[k-1];
				end
			end
		end
	end

	assign valid_s1_o = valid_s1;
	assign win_o      = win_s1;
	assign hist_o     = hist_q;

endmodule

// ----- rtl/core/thwf_eval.sv -----
// Second stage: tail and peak tests, grouped charge partial sums and hit times.
// Depends on thwf_pkg.
module thwf_eval (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  thwf_pkg::win_t      win,
	input  thwf_pkg::sample_t   hist [thwf_pkg::HIST_DEPTH],
	input  logic                s2_take,
	output logic                s1_take,
	output logic                valid_s2_o,
	output thwf_pkg::eval_t     eval_o
);
	import thwf_pkg::*;

	logic                     valid_s2;
	eval_t                    eval_s2;

	sample_t                  masked [HIST_DEPTH];
	logic                     tail_fail;
	logic [HIDX_W-1:0]        pb_idx;
	logic signed [PK_W-1:0]   peak_half;
	logic signed [PK_W-1:0]   thr2;
	logic signed [GSUM_W-1:0] acc;
	logic [PT_W-1:0]          pt;
	logic [EW_W:0]            two_w;
	eval_t                    eval_d;

	assign s1_take = !valid_s2 || s2_take;

	always_comb begin
		tail_fail = 1'b0;
		for (int k = 0; k < HIST_DEPTH; k++) begin
			if (HIDX_W'(k) >= HIDX_W'(win.lo) && HIDX_W'(k) <= win.hi) begin
				masked[k] = hist[k];
				if (hist[k] < win.tthr) begin
					tail_fail = 1'b1;
				end
			end else begin
				masked[k] = sample_t'(0);
			end
		end

		for (int g = 0; g < NGRP; g++) begin
			acc = '0;
			for (int j = 0; j < GRP; j++) begin
				if (g * GRP + j < HIST_DEPTH) begin
					acc = acc + GSUM_W'(masked[g * GRP + j]);
				end
			end
			eval_d.gsum[g] = acc;
		end

		// odd width: the center sample twice; even: center plus the next tick
		pb_idx    = win.even ? (win.dc - HIDX_W'(1)) : win.dc;
		peak_half = PK_W'(hist[win.dc]) + PK_W'(hist[pb_idx]);
		thr2      = PK_W'({win.pthr, 1'b0});

		pt    = PT_W'({win.c, win.even});
		two_w = {win.weff, 1'b0};

		eval_d.hit_ok    = win.elig && !tail_fail && (peak_half >= thr2);
		eval_d.plane     = win.plane;
		eval_d.wire_id   = win.wire_id;
		eval_d.pt        = pt;
		eval_d.st        = ST_W'(ST_W'(pt) - ST_W'(two_w));
		eval_d.et        = ET_W'(pt) + ET_W'(two_w);
		eval_d.peak_half = peak_half;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_take) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take && valid_s1) begin
			eval_s2 <= eval_d;
		end
	end

	assign valid_s2_o = valid_s2;
	assign eval_o     = eval_s2;

endmodule

// ----- rtl/core/thwf_out.sv -----
// Output register: final charge sum with saturation, drops non-passing candidates.
// Depends on thwf_pkg and thwf_hit_if.
module thwf_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s2,
	input  thwf_pkg::eval_t     eval_in,
	output logic                s2_take,
	thwf_hit_if.source          hits
);
	import thwf_pkg::*;

	logic                    out_valid_q;
	logic [PLANE_W-1:0]      plane_q;
	logic [WIRE_W-1:0]       wire_q;
	logic [PT_W-1:0]         pt_q;
	logic signed [ST_W-1:0]  st_q;
	logic [ET_W-1:0]         et_q;
	logic signed [CHG_W-1:0] charge_q;
	logic signed [PK_W-1:0]  peak_q;

	logic signed [ACC_W-1:0] sum;
	logic signed [CHG_W-1:0] charge_d;

	assign s2_take = !out_valid_q || hits.ready;

	always_comb begin
		sum = '0;
		for (int g = 0; g < NGRP; g++) begin
			sum = sum + ACC_W'($signed(eval_in.gsum[g]));
		end
		if (sum > ACC_W'(CHG_MAX)) begin
			charge_d = CHG_W'(CHG_MAX);
		end else if (sum < ACC_W'(CHG_MIN)) begin
			charge_d = CHG_W'(CHG_MIN);
		end else begin
			charge_d = CHG_W'(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_take) begin
			out_valid_q <= valid_s2 && eval_in.hit_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_take && valid_s2 && eval_in.hit_ok) begin
			plane_q  <= eval_in.plane;
			wire_q   <= eval_in.wire_id;
			pt_q     <= eval_in.pt;
			st_q     <= eval_in.st;
			et_q     <= eval_in.et;
			charge_q <= charge_d;
			peak_q   <= eval_in.peak_half;
		end
	end

	assign hits.valid           = out_valid_q;
	assign hits.hit_plane       = plane_q;
	assign hits.hit_wire        = wire_q;
	assign hits.peak_time_half  = pt_q;
	assign hits.start_time_half = st_q;
	assign hits.end_time_half   = et_q;
	assign hits.total_charge    = charge_q;
	assign hits.peak_value_half = peak_q;

endmodule

// ----- rtl/core/threshold_window_hit_finder.sv -----
// Threshold window hit finder, top level.
// Depends on thwf_pkg, thwf_if and the thwf_* stage modules.
//
// Usage:
//  - samples: one calibrated Q12.4 sample per request with its wire type, plane,
//    wire number and an end-of-wire mark. One request per cycle is sustained unless a stalled hit fills the pipeline.
//  - hits: at most one hit per sample request, in sample order. A hit for
//    candidate tick c leaves with the sample that completes its window.
//  - cfg_we/cfg_index/cfg_data: register writes (thresholds, widths), made while
//    the block is idle.
//  - Pipeline: an accepted sample is registered in the geometry stage, then the window test
//    stage, then the output register, where its hit is valid. Throughput: one sample per cycle
//    unless hits.ready stalls the three-register pipeline.
//  - Stalls: each stage loads whenever the one after it is empty or moving, so
//    bubbles fill while a hit waits; samples.ready drops only once all three
//    stages hold requests behind a stalled hit.
//  - Reset: tick counter and stage valids clear, registers take their defaults.
//    History needs no clear; ticks before the wire start are never read.
//  - End of wire: the tick counter restarts at zero for the next sample.
module threshold_window_hit_finder (
	input  logic                              clk,
	input  logic                              arst_n,
	thwf_sample_if.sink                       samples,
	thwf_hit_if.source                        hits,
	input  logic                              cfg_we,
	input  logic [thwf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [thwf_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import thwf_pkg::*;

	cfg_t     cfg;
	logic     valid_s1;
	win_t     win;
	sample_t  hist [HIST_DEPTH];
	logic     valid_s2;
	eval_t    eval_r;
	logic     s1_take;
	logic     s2_take;

	thwf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// History shift, tick count and per-sample window geometry
	thwf_window u_win (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.cfg        (cfg),
		.s1_take    (s1_take),
		.valid_s1_o (valid_s1),
		.win_o      (win),
		.hist_o     (hist)
	);

	// Tail/peak tests and partial charge sums
	thwf_eval u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.win        (win),
		.hist       (hist),
		.s2_take    (s2_take),
		.s1_take    (s1_take),
		.valid_s2_o (valid_s2),
		.eval_o     (eval_r)
	);

	// Final sum and result register
	thwf_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.eval_in  (eval_r),
		.s2_take  (s2_take),
		.hits     (hits)
	);

	// Full pipeline behind a stalled hit must back-pressure the sample side.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && hits.valid && !hits.ready) |-> !samples.ready)
		else $error("sample accepted while pipeline is full and stalled");

	// An accepted sample always occupies the first stage next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=> valid_s1)
		else $error("accepted sample lost before first stage");

	// A new hit can only come from a filled evaluation stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hits.valid) |-> $past(valid_s2))
		else $error("hit appeared without an evaluated candidate");

	// Passing candidate: end time lies strictly after the peak time.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && eval_r.hit_ok) |-> (eval_r.et > ET_W'(eval_r.pt)))
		else $error("hit end time not after peak time");

endmodule

// ----- tb/threshold_window_hit_finder_test.sv -----
// Self-checking testbench for threshold_window_hit_finder: drives wire samples and register
// writes, predicts every hit in step with the accepted sample requests and checks them in order.
// Depends on thwf_pkg, thwf_if and the block's RTL.
`timescale 1ns / 100ps

module threshold_window_hit_finder_test;
	import thwf_pkg::*;

	// One expected hit, laid out at the port widths.
	typedef struct packed {
		logic [PLANE_W-1:0]      plane;
		logic [WIRE_W-1:0]       wire_id;
		logic [PT_W-1:0]         peak_t;
		logic signed [ST_W-1:0]  start_t;
		logic [ET_W-1:0]         end_t;
		logic signed [CHG_W-1:0] charge;
		logic signed [PK_W-1:0]  peak_v;
	} hit_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	thwf_sample_if smp ();
	thwf_hit_if    hit ();

	threshold_window_hit_finder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (smp),
		.hits      (hit),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Mirror of the block's registers.
	sample_t           thr_peak_ind, thr_peak_col, thr_tail_ind, thr_tail_col;
	logic [WREG_W-1:0] wid_ind, wid_col;

	// Mirror of the per-wire history: index 0 is the newest sample.
	sample_t           history [0:MAX_WIDTH];
	logic [TICK_W-1:0] tick_now;

	hit_t expected_hits [$];

	int  samples_sent, wires_sent, hits_seen, mismatches;
	bit  quiet;      // no idling on either side
	bit  tx_steady;  // sender offers back to back
	int  rx_hold;    // cycles the receiver still holds off

	//------------------------------------------------------------------
	// Clock and run limit
	//------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Generous: the slowest legal run needs well under a millisecond.
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	//------------------------------------------------------------------
	// Hit predictor
	//------------------------------------------------------------------
	function automatic void clear_wire();
		int i;
		for (i = 0; i <= MAX_WIDTH; i++)
			history[i] = '0;
		tick_now = '0;
	endfunction

	// Shifts one sample into the history and tells whether it completes a
	// passing window; the hit is returned in h.
	function automatic bit find_hit(input sample_t s, input logic col,
			input logic [PLANE_W-1:0] pl, input logic [WIRE_W-1:0] wn,
			input logic last, output hit_t h);
		int w, span, t, b, c, dc, pk, chg, pthr, tthr, v, pt, i, k;
		bit ok;
		ok = 1'b0;
		h  = '0;
		// Ticks past the counter limit are dropped altogether.
		if (tick_now < MAX_TICKS) begin
			t    = tick_now;
			w    = col ? wid_col : wid_ind;
			// A width of zero acts as one, oversize clamps to the maximum.
			if (w < 1)
				w = 1;
			if (w > MAX_WIDTH)
				w = MAX_WIDTH;
			pthr = col ? thr_peak_col : thr_peak_ind;
			tthr = col ? thr_tail_col : thr_tail_ind;
			// Width two needs the tick after the window for its peak.
			span = (w == 2) ? 3 : w;
			for (i = MAX_WIDTH; i > 0; i--)
				history[i] = history[i-1];
			history[0] = s;
			// Only windows that start at or after tick zero qualify.
			if (t + 1 >= span) begin
				b   = t + 1 - span;
				c   = b + w / 2;
				dc  = t - c;
				if (w % 2)
					pk = 2 * history[dc];
				else
					pk = history[dc] + history[dc-1];
				ok  = (pk >= 2 * pthr);
				chg = 0;
				for (k = 0; k < w; k++) begin
					v = history[t - (b + k)];
					if (v < tthr)
						ok = 1'b0;
					chg += v;
				end
				if (ok) begin
					pt = 2 * c + ((w % 2) ? 0 : 1);
					if (chg > CHG_MAX)
						chg = CHG_MAX;
					if (chg < CHG_MIN)
						chg = CHG_MIN;
					// Type, plane and wire come from the completing sample.
					h.plane   = pl;
					h.wire_id = wn;
					h.peak_t  = pt[PT_W-1:0];
					h.start_t = ST_W'(pt - 2 * w);
					h.end_t   = ET_W'(pt + 2 * w);
					h.charge  = chg[CHG_W-1:0];
					h.peak_v  = pk[PK_W-1:0];
				end
			end
			tick_now = TICK_W'(t + 1);
		end
		if (last)
			clear_wire();
		return ok;
	endfunction

	//------------------------------------------------------------------
	// Stimulus helpers
	//------------------------------------------------------------------
	task automatic tx_pause(input int n);
		smp.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Offers one sample request, waits for it to be taken and records
	// the hit it should produce. Valid is left high for the next request unless a random pause follows.
	task automatic send_sample(input sample_t s, input logic col,
			input logic [PLANE_W-1:0] pl, input logic [WIRE_W-1:0] wn,
			input logic last);
		hit_t h;
		smp.valid         <= 1'b1;
		smp.sample        <= s;
		smp.is_collection <= col;
		smp.plane         <= pl;
		smp.wire_number   <= wn;
		smp.last_of_wire  <= last;
		do
			@(posedge clk);
		while (!smp.ready);
		samples_sent++;
		if (last)
			wires_sent++;
		if (find_hit(s, col, pl, wn, last, h))
			expected_hits.insert(expected_hits.size(), h);
		if (!quiet && !tx_steady && $urandom_range(0, 5) == 0)
			tx_pause($urandom_range(1, 11));
	endtask

	// Drops valid, waits for every outstanding hit and lets the pipeline
	// empty of requests that carry no hit.
	task automatic wait_idle();
		smp.valid <= 1'b0;
		while (expected_hits.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Writes all six registers on consecutive edges, mirroring each one.
	task automatic program_config(input sample_t pi, input sample_t pc,
			input sample_t ti, input sample_t tc,
			input logic [WREG_W-1:0] wi, input logic [WREG_W-1:0] wc);
		logic [CFG_DATA_W-1:0] word [0:5];
		cfg_reg_e              sel;
		word[REG_PEAK_IND]  = pi;
		word[REG_PEAK_COL]  = pc;
		word[REG_TAIL_IND]  = ti;
		word[REG_TAIL_COL]  = tc;
		// Width writes carry random upper bits, which the block drops.
		word[REG_WIDTH_IND] = CFG_DATA_W'($urandom);
		word[REG_WIDTH_IND][WREG_W-1:0] = wi;
		word[REG_WIDTH_COL] = CFG_DATA_W'($urandom);
		word[REG_WIDTH_COL][WREG_W-1:0] = wc;
		cfg_we <= 1'b1;
		sel = REG_PEAK_IND;
		do begin
			cfg_index <= sel;
			cfg_data  <= word[sel];
			@(posedge clk);
			sel = sel.next();
		end while (sel != REG_PEAK_IND);
		cfg_we <= 1'b0;
		thr_peak_ind = pi;
		thr_peak_col = pc;
		thr_tail_ind = ti;
		thr_tail_col = tc;
		wid_ind      = wi;
		wid_col      = wc;
	endtask

	// Mostly pulse-like values, some near the thresholds, some full range.
	function automatic sample_t rand_sample();
		case ($urandom_range(0, 9))
			0: return sample_t'($urandom);
			1: begin
				case ($urandom_range(0, 5))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return thr_peak_ind;
					3: return sample_t'(thr_peak_col + 1);
					4: return sample_t'(thr_tail_ind - 1);
					default: return thr_tail_col;
				endcase
			end
			2, 3, 4, 5: return sample_t'($urandom_range(0, 3000) - 500);
			default: return sample_t'($urandom_range(0, 600) - 300);
		endcase
	endfunction

	function automatic logic [WREG_W-1:0] pick_width();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return WREG_W'(2);
			2: return WREG_W'(MAX_WIDTH);
			3: return WREG_W'($urandom_range(MAX_WIDTH + 1, 31));
			default: return WREG_W'($urandom_range(1, MAX_WIDTH));
		endcase
	endfunction

	// One wire of random content; now and then the type flips mid-wire.
	task automatic send_wire(input int len);
		logic               col;
		logic [PLANE_W-1:0] pl;
		logic [WIRE_W-1:0]  wn;
		int                 i;
		col = 1'($urandom_range(0, 1));
		pl  = PLANE_W'($urandom_range(0, 2));
		wn  = WIRE_W'($urandom);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 24) == 0)
				col = ~col;
			if ($urandom_range(0, 49) == 0)
				pl = PLANE_W'($urandom_range(0, 2));
			send_sample(rand_sample(), col, pl, wn, i == len - 1);
		end
	endtask

	//------------------------------------------------------------------
	// Tests
	//------------------------------------------------------------------

	// Reset settings: width three, peak at zero, tail at -1584.
	task automatic test_threshold_edges();
		// Full-scale samples, then a minimum that breaks every later window.
		send_sample(16'sh7FFF, 1'b0, 2'd0, 16'h0000, 1'b0);
		send_sample(16'sh7FFF, 1'b0, 2'd0, 16'h0000, 1'b0);
		send_sample(16'sh7FFF, 1'b0, 2'd0, 16'h0000, 1'b0);
		send_sample(16'sh8000, 1'b0, 2'd0, 16'h0000, 1'b0);
		send_sample(-16'sd1584, 1'b0, 2'd0, 16'h0000, 1'b0);
		send_sample(-16'sd1584, 1'b0, 2'd0, 16'h0000, 1'b1);
		// Peak exactly at its threshold, tails exactly at theirs.
		send_sample(-16'sd1584, 1'b1, 2'd2, 16'hFFFF, 1'b0);
		send_sample(16'sd0, 1'b1, 2'd2, 16'hFFFF, 1'b0);
		send_sample(-16'sd1584, 1'b1, 2'd2, 16'hFFFF, 1'b1);
		// Wires shorter than the window give nothing.
		send_sample(16'sd100, 1'b0, 2'd1, 16'h5A5A, 1'b0);
		send_sample(16'sd100, 1'b0, 2'd1, 16'h5A5A, 1'b1);
		send_sample(16'sd900, 1'b1, 2'd1, 16'hA5A5, 1'b1);
		wait_idle();
	endtask

	// Width zero, width two, and a hit finished by a sample of the other type.
	task automatic test_width_special_cases();
		program_config(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 5'd0, 5'd2);
		// Induction width acts as one; only full scale reaches the peak.
		send_sample(16'sh7FFF, 1'b0, 2'd0, 16'd7, 1'b0);
		send_sample(16'sh7FFE, 1'b0, 2'd0, 16'd7, 1'b0);
		send_sample(16'sh7FFF, 1'b0, 2'd0, 16'd7, 1'b1);
		// Width two: the hit leaves with the tick after its window.
		send_sample(16'sd5, 1'b1, 2'd1, 16'd8, 1'b0);
		send_sample(16'sd7, 1'b1, 2'd1, 16'd8, 1'b0);
		send_sample(16'sd9, 1'b1, 2'd1, 16'd8, 1'b1);
		// Mixed wire data: the last sample switches to induction settings.
		send_sample(16'sd10, 1'b1, 2'd2, 16'd9, 1'b0);
		send_sample(16'sd20, 1'b1, 2'd2, 16'd9, 1'b0);
		send_sample(16'sh7FFF, 1'b0, 2'd1, 16'd10, 1'b1);
		wait_idle();
	endtask

	// One long wire at the widest window; every full window is a hit.
	task automatic test_long_wire();
		int i;
		program_config(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 5'd1,
			WREG_W'(MAX_WIDTH));
		for (i = 0; i < 200; i++)
			send_sample(rand_sample(), 1'b1, 2'd2, 16'hC0DE, i == 199);
		wait_idle();
	endtask

	// Receiver holds off while every sample makes a hit, so the pipeline
	// fills and the sample side has to stall.
	task automatic test_output_stall();
		int i;
		program_config(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 5'd1, 5'd1);
		tx_steady = 1'b1;
		rx_hold   = 300;
		for (i = 0; i < 80; i++)
			send_sample(rand_sample(), 1'b0, 2'd1, 16'd1234, i == 79);
		tx_steady = 1'b0;
		// Sender pauses until the backlog has drained.
		wait_idle();
	endtask

	// Random wires under several settings; the last phase runs without idling.
	task automatic test_random_wires();
		int ph, n, len;
		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: program_config(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
					pick_width(), pick_width());
				1: program_config(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
					pick_width(), pick_width());
				2: program_config(16'sd0, 16'sd0, -16'sd1584, -16'sd1584,
					WREG_W'(MAX_WIDTH), 5'd31);
				default: program_config(sample_t'($urandom_range(0, 1500) - 200),
					sample_t'($urandom_range(0, 1500) - 200),
					sample_t'(-$urandom_range(0, 2000)),
					sample_t'(-$urandom_range(0, 2000)), pick_width(), pick_width());
			endcase
			quiet = (ph == 7);
			n = 0;
			while (n < 200) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3)
					: $urandom_range(1, 40);
				send_wire(len);
				n += len;
			end
			wait_idle();
		end
	endtask

	//------------------------------------------------------------------
	// Receiver: random stall bursts, one long hold-off on request
	//------------------------------------------------------------------
	initial begin
		int burst;
		burst     = 0;
		hit.ready = 1'b1;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				hit.ready <= 1'b0;
				rx_hold--;
			end else if (quiet) begin
				hit.ready <= 1'b1;
			end else if (burst > 0) begin
				hit.ready <= 1'b0;
				burst--;
			end else if ($urandom_range(0, 7) == 0) begin
				hit.ready <= 1'b0;
				burst = $urandom_range(0, 10);
			end else begin
				hit.ready <= 1'b1;
			end
		end
	end

	//------------------------------------------------------------------
	// Hit checker: each accepted hit against the oldest prediction
	//------------------------------------------------------------------
	function automatic void check_field(input string name, input longint want,
			input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		hit_t want;
		if (hit.valid && hit.ready) begin
			hits_seen++;
			if (expected_hits.size() == 0) begin
				$error("unexpected hit: wire %0d, peak_time_half %0d",
					hit.hit_wire, hit.peak_time_half);
				mismatches++;
			end else begin
				want = expected_hits.pop_front();
				check_field("hit_plane", want.plane, hit.hit_plane);
				check_field("hit_wire", want.wire_id, hit.hit_wire);
				check_field("peak_time_half", want.peak_t, hit.peak_time_half);
				check_field("start_time_half", want.start_t, hit.start_time_half);
				check_field("end_time_half", want.end_t, hit.end_time_half);
				check_field("total_charge", want.charge, hit.total_charge);
				check_field("peak_value_half", want.peak_v, hit.peak_value_half);
			end
		end
	end

	//------------------------------------------------------------------
	// Main sequence
	//------------------------------------------------------------------
	initial begin
		arst_n            = 1'b0;
		smp.valid         = 1'b0;
		smp.sample        = '0;
		smp.is_collection = 1'b0;
		smp.plane         = '0;
		smp.wire_number   = '0;
		smp.last_of_wire  = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = REG_PEAK_IND;
		cfg_data          = '0;
		quiet             = 1'b0;
		tx_steady         = 1'b0;
		rx_hold           = 0;
		samples_sent      = 0;
		wires_sent        = 0;
		hits_seen         = 0;
		mismatches        = 0;
		// Register defaults after reset.
		thr_peak_ind      = 16'sd0;
		thr_peak_col      = 16'sd0;
		thr_tail_ind      = -16'sd1584;
		thr_tail_col      = -16'sd1584;
		wid_ind           = 5'd3;
		wid_col           = 5'd3;
		clear_wire();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_threshold_edges();
		test_width_special_cases();
		test_output_stall();
		test_long_wire();
		test_random_wires();

		// Last phase already drained; waiting longer catches stray hits.
		wait_idle();
		repeat (10) @(posedge clk);
		if (expected_hits.size() != 0) begin
			$error("%0d predicted hits never arrived", expected_hits.size());
			mismatches++;
		end

		$display("Covered %0d samples on %0d wires, %0d hits checked,", samples_sent,
			wires_sent, hits_seen);
		$display("widths 0 to 31, threshold extremes, a long full-width wire, stalls.");
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
